// ===== sv/fpa_pkg.sv =====
// Shared types, opcodes and helpers of the fixed-point ALU.
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int W         = 32;
  localparam int QW        = W + FRAC_BITS;  // divider quotient width, one stage per bit

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } func_t;

  // one word in flight through the divider chain
  typedef struct packed {
    logic          vld;
    func_t         func;
    logic [W-1:0]  a;
    logic [W-1:0]  mb;    // |b|
    logic          neg;   // signs of a and b differ
    logic          bz;    // b is zero
    logic [W-1:0]  rem;
    logic [QW-1:0] quo;
    logic [QW-1:0] num;   // numerator bits still to shift in, MSB first
    logic [W-1:0]  res;   // result of every non-divide op
    logic          cmp;
    logic          ovf;
  } div_st_t;

  typedef struct packed {
    logic [W-1:0] v;
    logic         ovf;
  } sat_t;

  // signed value from sign and magnitude, saturated to 32 bits
  function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
    sat_t s;
    s.ovf = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        s.v   = 32'h8000_0000;
        s.ovf = 1'b1;
      end else begin
        s.v = 32'(-mag);
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        s.v   = 32'h7FFF_FFFF;
        s.ovf = 1'b1;
      end else begin
        s.v = mag[W-1:0];
      end
    end
    return s;
  endfunction

endpackage

// ===== sv/fpa_div_stage.sv =====
// One restoring-division step: one quotient bit per stage, registered.
module fpa_div_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  fpa_pkg::div_st_t d,
  output fpa_pkg::div_st_t q
);

  fpa_pkg::div_st_t q_r, q_nxt;
  logic [fpa_pkg::W:0] rem_sh, diff;

  always_comb begin
    rem_sh = {d.rem, d.num[fpa_pkg::QW-1]};
    diff   = rem_sh - {1'b0, d.mb};
    q_nxt  = d;
    q_nxt.num = {d.num[fpa_pkg::QW-2:0], 1'b0};
    if (!diff[fpa_pkg::W]) begin
      q_nxt.rem = diff[fpa_pkg::W-1:0];
      q_nxt.quo = {d.quo[fpa_pkg::QW-2:0], 1'b1};
    end else begin
      q_nxt.rem = rem_sh[fpa_pkg::W-1:0];
      q_nxt.quo = {d.quo[fpa_pkg::QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== sv/fixed_point_alu_top.sv =====
// Top level of the pipelined signed fixed-point ALU.
//
// Usage:
//  - Input channel (in_*): one operation per word. in_tuser carries the
//    opcode, in_tdata the two raw fixed-point operands.
//  - Output channel (out_*): one result word per operation, in order, with
//    the result and the compare, divide-by-zero and overflow flags.
//  - Path: every opcode takes the same route from acceptance to out_tvalid,
//    through stage 1, stage 2, the divider, which retires one quotient
//    bit per stage over 32 + FRAC_BITS stages, and the output register.
//  - Throughput: one word per cycle; a new word may enter each unstalled cycle.
//  - Stall: when out_tvalid is high and out_tready low the whole pipeline
//    holds, in_tready drops in the same cycle and nothing is lost or
//    repeated. Stages left empty by bubbles still travel with the flow.
//  - Reset (rst_n low, synchronous): all valid bits clear; data registers
//    keep whatever they held.
module fixed_point_alu_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  logic [3:0]  in_tuser,   // [3:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] result, [32] compare_true,
                                  // [33] divide_by_zero, [34] overflow, zero pad
);

  localparam int W  = fpa_pkg::W;
  localparam int QW = fpa_pkg::QW;
  localparam int FB = fpa_pkg::FRAC_BITS;

  // first stage: operand decode, simple ops, raw product
  typedef struct packed {
    logic             vld;
    fpa_pkg::func_t   func;
    logic [W-1:0]     a;
    logic [W-1:0]     mb;
    logic             neg;
    logic             bz;
    logic [QW-1:0]    num;
    logic [2*W-1:0]   prod;
    logic [W-1:0]     res;
    logic             cmp;
    logic             ovf;
  } s1_t;

  logic advance;
  s1_t s1_r, s1_nxt;
  fpa_pkg::div_st_t st [QW+1];   // st[0] is the rounding stage register
  fpa_pkg::div_st_t s2_nxt;

  logic [39:0] out_tdata_r, out_tdata_nxt;
  logic        out_tvalid_r;

  // whole pipe moves when the output slot is free or being drained
  assign advance   = !out_tvalid_r || out_tready;
  assign in_tready = advance;

  // ---- stage 1 ----
  logic signed [W-1:0] a_s, b_s;
  logic [W:0]          sum33;
  fpa_pkg::sat_t       fi;

  function automatic fpa_pkg::sat_t clamp33(input logic [W:0] v);
    fpa_pkg::sat_t s;
    s.ovf = v[W] != v[W-1];
    s.v   = s.ovf ? (v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}}) : v[W-1:0];
    return s;
  endfunction

  always_comb begin
    fpa_pkg::sat_t cs;
    a_s = in_tdata[W-1:0];
    b_s = in_tdata[2*W-1:W];
    s1_nxt.vld  = in_tvalid;
    s1_nxt.func = fpa_pkg::func_t'(in_tuser);
    s1_nxt.a    = a_s;
    s1_nxt.mb   = b_s[W-1] ? W'(-b_s) : b_s;
    s1_nxt.neg  = a_s[W-1] != b_s[W-1];
    s1_nxt.bz   = b_s == '0;
    s1_nxt.num  = {(a_s[W-1] ? W'(-a_s) : W'(a_s)), {FB{1'b0}}};
    s1_nxt.prod = (a_s[W-1] ? W'(-a_s) : W'(a_s)) * s1_nxt.mb;
    s1_nxt.res  = '0;
    s1_nxt.cmp  = 1'b0;
    s1_nxt.ovf  = 1'b0;
    sum33 = '0;
    fi = fpa_pkg::sat_mag(a_s[W-1], {32'b0, s1_nxt.num[QW-1:FB]} << FB);
    cs = '0;
    case (s1_nxt.func)
      fpa_pkg::OP_ADD: begin
        sum33 = {a_s[W-1], a_s} + {b_s[W-1], b_s};
        cs = clamp33(sum33);
        s1_nxt.res = cs.v;
        s1_nxt.ovf = cs.ovf;
      end
      fpa_pkg::OP_SUB: begin
        sum33 = {a_s[W-1], a_s} - {b_s[W-1], b_s};
        cs = clamp33(sum33);
        s1_nxt.res = cs.v;
        s1_nxt.ovf = cs.ovf;
      end
      fpa_pkg::OP_GT: s1_nxt.cmp = a_s > b_s;
      fpa_pkg::OP_LT: s1_nxt.cmp = a_s < b_s;
      fpa_pkg::OP_GE: s1_nxt.cmp = a_s >= b_s;
      fpa_pkg::OP_LE: s1_nxt.cmp = a_s <= b_s;
      fpa_pkg::OP_EQ: s1_nxt.cmp = a_s == b_s;
      fpa_pkg::OP_NE: s1_nxt.cmp = a_s != b_s;
      fpa_pkg::OP_MIN: s1_nxt.res = (a_s < b_s) ? a_s : b_s;
      fpa_pkg::OP_MAX: s1_nxt.res = (a_s > b_s) ? a_s : b_s;
      fpa_pkg::OP_INC: begin
        sum33 = {a_s[W-1], a_s} + (W+1)'(1);
        cs = clamp33(sum33);
        s1_nxt.res = cs.v;
        s1_nxt.ovf = cs.ovf;
      end
      fpa_pkg::OP_DEC: begin
        sum33 = {a_s[W-1], a_s} - (W+1)'(1);
        cs = clamp33(sum33);
        s1_nxt.res = cs.v;
        s1_nxt.ovf = cs.ovf;
      end
      fpa_pkg::OP_FROM_INT: begin
        s1_nxt.res = fi.v;
        s1_nxt.ovf = fi.ovf;
      end
      fpa_pkg::OP_TO_INT: s1_nxt.res = a_s >>> FB;
      default: ;  // mul and div finish later
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (advance) begin
      s1_r <= s1_nxt;
    end
  end

  // ---- stage 2: product rounding, divider setup ----
  always_comb begin
    fpa_pkg::sat_t ms;
    ms = fpa_pkg::sat_mag(s1_r.neg, (s1_r.prod + (64'(1) << (FB-1))) >> FB);
    s2_nxt.vld  = s1_r.vld;
    s2_nxt.func = s1_r.func;
    s2_nxt.a    = s1_r.a;
    s2_nxt.mb   = s1_r.mb;
    s2_nxt.neg  = s1_r.neg;
    s2_nxt.bz   = s1_r.bz;
    s2_nxt.rem  = '0;
    s2_nxt.quo  = '0;
    s2_nxt.num  = s1_r.num;
    s2_nxt.res  = s1_r.res;
    s2_nxt.cmp  = s1_r.cmp;
    s2_nxt.ovf  = s1_r.ovf;
    if (s1_r.func == fpa_pkg::OP_MUL) begin
      s2_nxt.res = ms.v;
      s2_nxt.ovf = ms.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st[0].vld <= 1'b0;
    end else if (advance) begin
      st[0] <= s2_nxt;
    end
  end

  // ---- divider chain ----
  for (genvar k = 0; k < QW; k++) begin : g_div
    fpa_div_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (advance),
      .d     (st[k]),
      .q     (st[k+1])
    );
  end

  // ---- final: quotient rounding, output register ----
  always_comb begin
    fpa_pkg::div_st_t f;
    fpa_pkg::sat_t    ds;
    logic             rnd;
    logic [31:0]      res;
    logic             dz, ovf;
    f   = st[QW];
    rnd = {f.rem, 1'b0} >= {1'b0, f.mb};
    ds  = fpa_pkg::sat_mag(f.neg, 64'(f.quo) + 64'(rnd));
    res = f.res;
    ovf = f.ovf;
    dz  = 1'b0;
    if (f.func == fpa_pkg::OP_DIV) begin
      if (f.bz) begin
        res = f.a;
        dz  = 1'b1;
        ovf = 1'b0;
      end else begin
        res = ds.v;
        ovf = ds.ovf;
      end
    end
    out_tdata_nxt = {5'b0, ovf, dz, f.cmp, res};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (advance) begin
      out_tvalid_r <= st[QW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== sv/fpa_checker.sv =====
// Port-level checks of the fixed-point ALU, bound to the top level.
module fpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid after reset");

  // a held result word stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled word changed");

  // input is taken exactly when the output slot can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready out of step with output");

  // a word never carries more than one of the three flags
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[34:32]))
    else $error("conflicting result flags");

endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/fixed_point_alu_checker.sv =====
// Output checker: predicts each ALU result and compares it on the result channel.
`timescale 1ns / 100ps
module fixed_point_alu_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [3:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] res;
    logic        cmp;
    logic        dz;
    logic        ovf;
  } alu_res_t;

  alu_res_t expected_q[$];

  function automatic logic [63:0] mag_of(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // saturate a sign/magnitude pair to 32 bits
  function automatic void clamp_sm(input logic neg, input logic [63:0] m,
                                   output logic [31:0] r, output logic o);
    o = 1'b0;
    if (neg) begin
      if (m > 64'h8000_0000) begin r = 32'h8000_0000; o = 1'b1; end
      else r = 32'(-m);
    end else begin
      if (m > 64'h7FFF_FFFF) begin r = 32'h7FFF_FFFF; o = 1'b1; end
      else r = m[31:0];
    end
  endfunction

  function automatic alu_res_t alu_predict(input fpa_pkg::func_t f,
                                           input logic [31:0] ra,
                                           input logic [31:0] rb);
    alu_res_t x;
    logic signed [63:0] a, b, s;
    logic [63:0] ma, mb, p, q, r;
    logic neg;
    x = '0;
    a = 64'(signed'(ra));
    b = 64'(signed'(rb));
    ma = mag_of(a);
    mb = mag_of(b);
    neg = (a < 0) != (b < 0);
    case (f)
      fpa_pkg::OP_ADD:  clamp_sm(a + b < 0, mag_of(a + b), x.res, x.ovf);
      fpa_pkg::OP_SUB:  clamp_sm(a - b < 0, mag_of(a - b), x.res, x.ovf);
      fpa_pkg::OP_INC:  clamp_sm(a + 1 < 0, mag_of(a + 1), x.res, x.ovf);
      fpa_pkg::OP_DEC:  clamp_sm(a - 1 < 0, mag_of(a - 1), x.res, x.ovf);
      fpa_pkg::OP_MUL: begin
        p = ma * mb;
        clamp_sm(neg, (p + (64'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS,
                 x.res, x.ovf);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          x.dz = 1'b1;
          x.res = ra;
        end else begin
          q = (ma << fpa_pkg::FRAC_BITS) / mb;
          r = (ma << fpa_pkg::FRAC_BITS) % mb;
          if (2 * r >= mb) q++;
          clamp_sm(neg, q, x.res, x.ovf);
        end
      end
      fpa_pkg::OP_GT:   x.cmp = a > b;
      fpa_pkg::OP_LT:   x.cmp = a < b;
      fpa_pkg::OP_GE:   x.cmp = a >= b;
      fpa_pkg::OP_LE:   x.cmp = a <= b;
      fpa_pkg::OP_EQ:   x.cmp = a == b;
      fpa_pkg::OP_NE:   x.cmp = a != b;
      fpa_pkg::OP_MIN:  x.res = a < b ? ra : rb;
      fpa_pkg::OP_MAX:  x.res = a > b ? ra : rb;
      fpa_pkg::OP_FROM_INT: clamp_sm(a < 0, ma << fpa_pkg::FRAC_BITS, x.res, x.ovf);
      default: begin
        s = a >>> fpa_pkg::FRAC_BITS;
        x.res = s[31:0];
      end
    endcase
    return x;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    alu_res_t want, got;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_q.push_back(alu_predict(fpa_pkg::func_t'(in_tuser),
                                         in_tdata[31:0], in_tdata[63:32]));
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[32], out_tdata[33], out_tdata[34]};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== got || out_tdata[39:35] !== 5'd0) begin
            $display({"%0t: mismatch exp res=%h cmp=%b dz=%b ovf=%b",
                      " got res=%h cmp=%b dz=%b ovf=%b pad=%b"},
                     $time, want.res, want.cmp, want.dz, want.ovf,
                     got.res, got.cmp, got.dz, got.ovf, out_tdata[39:35]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/fixed_point_alu_top_tb.sv =====
// Testbench top: drives operation words into the fixed-point ALU and gives the verdict.
`timescale 1ns / 100ps
module fixed_point_alu_top_tb;

  localparam int N_RANDOM    = 1500;
  localparam int CYCLE_LIMIT = 400000;  // ~1500 words with worst-case gaps and stalls, x4

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;     // [31:0] operand_a, [63:32] operand_b
  logic [3:0]  in_tuser = '0;     // [3:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [31:0] result, [32] cmp, [33] dz, [34] ovf
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          calm = 1'b0;       // no idling in the closing stretch

  always #2 clk = ~clk;

  fixed_point_alu_top i_dut (.*);

  fixed_point_alu_checker i_chk (.*);

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fixed_point_alu_top test failed");
      $finish;
    end
  end

  // receiver: ready with random stall bursts
  initial begin
    int n;
    repeat (5) @(posedge clk);
    forever begin
      n = $urandom_range(1, 16);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat (n) @(posedge clk);
    end
  end

  // send one word; holds until accepted
  task automatic send_op(input fpa_pkg::func_t f, input logic [31:0] a,
                         input logic [31:0] b);
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(1, 16);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // operands biased toward the edges of the range
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'($urandom_range(0, 4)) - 32'd2;
      3: return 32'(signed'($urandom_range(0, 1 << 16)) - (1 << 15));
      4: return 32'(signed'($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] ext[6];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every opcode at the extremes, plus the named corner cases
    ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h100, 32'hFFFF_FF00};
    for (int f = 0; f < 16; f++)
      send_op(fpa_pkg::func_t'(f), ext[f % 6], ext[(f + 1) % 6]);
    send_op(fpa_pkg::OP_DIV, 32'h1234_5678, 32'h0);          // divide by zero
    send_op(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0);
    send_op(fpa_pkg::OP_INC, 32'h7FFF_FFFF, 32'h0);          // increment past the top
    send_op(fpa_pkg::OP_DEC, 32'h8000_0000, 32'h0);          // decrement past the bottom
    send_op(fpa_pkg::OP_FROM_INT, 32'h0080_0000, 32'h0);     // from_int overflow
    send_op(fpa_pkg::OP_FROM_INT, 32'hFF80_0000, 32'h0);     // exactly the negative bound
    send_op(fpa_pkg::OP_TO_INT, 32'hFFFF_FFFF, 32'h0);       // rounds toward minus infinity
    send_op(fpa_pkg::OP_MIN, 32'h55, 32'h55);                // equal operands
    send_op(fpa_pkg::OP_MAX, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_op(fpa_pkg::OP_MUL, 32'h80, 32'h1);                 // half rounds away from zero

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 200) calm = 1'b1;
      gap();
      send_op(fpa_pkg::func_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (fpa_pkg::FRAC_BITS + 50) @(posedge clk);
    if (fail_count == 0)
      $display("fixed_point_alu_top test passed");
    else
      $display("fixed_point_alu_top test failed");
    $finish;
  end

endmodule
